// ===== rtl/sssf_pkg.sv =====
// ----------------------------------------------------------------------------
// sssf_pkg: shared types and constants of the snapshot session controller
// Phase, action and blocker codes, event kinds, stream widths and the
// structures that pass between the decision logic and the result stage.
// ----------------------------------------------------------------------------
package sssf_pkg;

  // Sizes of the stored chunk root and of the chunk counters.
  localparam int ROOT_WORDS    = 4;
  localparam int ROOT_IN_WORDS = 4;
  localparam int COUNT_BITS    = 32;

  // Stream widths; the data widths are whole bytes.
  localparam int IN_DATA_W  = 456;
  localparam int IN_USER_W  = 5;
  localparam int OUT_DATA_W = 232;
  localparam int OUT_USER_W = 4;

  // Event kinds carried in the input tuser field.
  localparam logic [4:0] EV_START    = 5'd0;
  localparam logic [4:0] EV_OFFER    = 5'd1;
  localparam logic [4:0] EV_MANIFEST = 5'd2;
  localparam logic [4:0] EV_ACCEPTED = 5'd3;
  localparam logic [4:0] EV_CHUNK    = 5'd4;
  localparam logic [4:0] EV_REJECT   = 5'd5;
  localparam logic [4:0] EV_COMPLETE = 5'd6;
  localparam logic [4:0] EV_PROOF    = 5'd7;
  localparam logic [4:0] EV_FAIL     = 5'd8;
  localparam logic [4:0] EV_LOST     = 5'd9;
  localparam logic [4:0] EV_TIMEOUT  = 5'd10;
  localparam logic [4:0] EV_STOP     = 5'd11;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_NEG     = 3'd1,
    PH_RECV    = 3'd2,
    PH_VERIFY  = 3'd3,
    PH_STAGED  = 3'd4,
    PH_CONTAIN = 3'd5,
    PH_FAILED  = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    ACT_NONE    = 4'd0,
    ACT_STORE   = 4'd1,
    ACT_RESET   = 4'd2,
    ACT_BEGIN   = 4'd3,
    ACT_APPLY   = 4'd4,
    ACT_PENAL   = 4'd5,
    ACT_VERIFY  = 4'd6,
    ACT_STAGE   = 4'd7,
    ACT_CONTAIN = 4'd8,
    ACT_FAIL    = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    BLK_NONE      = 3'd0,
    BLK_PROOF     = 3'd1,
    BLK_PEER_LOST = 3'd2,
    BLK_TIMEOUT   = 3'd3,
    BLK_CONTAINED = 3'd4
  } blocker_e;

  // One input event as held in the input register.
  typedef struct packed {
    logic [4:0]                         mode;
    logic [63:0]                        session_tag;
    logic [63:0]                        peer_tag;
    logic [31:0]                        offer_height;
    logic [31:0]                        offer_chunk_total;
    logic                               manifest_accept;
    logic                               proof_passed;
    logic [ROOT_IN_WORDS-1:0][63:0]     root;
  } event_t;

  // Session state kept between events.
  typedef struct packed {
    phase_e                             phase;
    logic [63:0]                        session;
    logic [63:0]                        peer;
    logic [31:0]                        height;
    logic [COUNT_BITS-1:0]              total;
    logic [COUNT_BITS-1:0]              received;
    logic [ROOT_WORDS-1:0][63:0]        root;
    logic                               proven;
  } state_t;

  // Everything the result stage needs to present the results of one event.
  typedef struct packed {
    phase_e                             phase;
    action_e                            act0;
    action_e                            act1;
    logic                               two;
    blocker_e                           blocker;
    logic                               blocker_valid;
    logic [63:0]                        session;
    logic [63:0]                        peer;
    logic [31:0]                        height;
    logic [31:0]                        total;
    logic [31:0]                        received;
    logic                               proven;
  } record_t;

endpackage

// ===== rtl/sssf_decide.sv =====
// ----------------------------------------------------------------------------
// sssf_decide: event decision and state update
// Works out, from the current session state and one event, the state after
// the event and the record of the one or two results that it gives.
// ----------------------------------------------------------------------------
module sssf_decide (
  input  sssf_pkg::state_t  state_i,
  input  sssf_pkg::event_t  event_i,
  output sssf_pkg::state_t  state_o,
  output sssf_pkg::record_t record_o
);
  import sssf_pkg::*;

  logic [ROOT_WORDS-1:0][63:0] ev_root;
  logic                        root_set;
  logic                        root_same;
  logic                        stale;
  logic                        live;
  phase_e                      next_ph;
  logic [1:0]                  act_cnt;
  action_e                     act0;
  action_e                     act1;
  blocker_e                    blk;
  logic                        blk_valid;
  state_t                      nx;
  logic [63:0]                 total_ext;
  logic [63:0]                 recv_ext;

  // Event root widened to the stored root; missing words read as zero.
  always_comb begin
    for (int i = 0; i < ROOT_WORDS; i++) begin
      ev_root[i] = (i < ROOT_IN_WORDS) ? event_i.root[i % ROOT_IN_WORDS] : 64'd0;
    end
  end

  // Compare the stored root with the event root, word by word.
  always_comb begin
    root_set  = 1'b0;
    root_same = 1'b1;
    for (int i = 0; i < ROOT_WORDS; i++) begin
      if (state_i.root[i] != 64'd0) root_set = 1'b1;
      if (state_i.root[i] != ev_root[i]) root_same = 1'b0;
    end
  end

  // Events for another stored session and foreign chunks are ignored.
  assign stale = ((state_i.session != 64'd0) && (state_i.session != event_i.session_tag)) ||
                 ((event_i.mode == EV_CHUNK) && root_set && !root_same);

  assign live = (state_i.phase == PH_NEG) || (state_i.phase == PH_RECV) ||
                (state_i.phase == PH_VERIFY);

  // Phase transition and the actions it calls for.
  always_comb begin
    next_ph   = state_i.phase;
    act_cnt   = 2'd0;
    act0      = ACT_NONE;
    act1      = ACT_NONE;
    blk       = BLK_NONE;
    blk_valid = 1'b0;
    if ((state_i.phase > PH_FAILED) || (event_i.mode > EV_STOP)) begin
      next_ph = state_i.phase;
    end else if (event_i.mode == EV_STOP) begin
      next_ph = PH_IDLE;
    end else if (live && (event_i.mode >= EV_FAIL) && (event_i.mode <= EV_TIMEOUT)) begin
      next_ph   = PH_FAILED;
      act_cnt   = 2'd1;
      act0      = ACT_FAIL;
      blk       = blocker_e'(3'(event_i.mode - EV_PROOF));
      blk_valid = 1'b1;
    end else begin
      case (state_i.phase)
        PH_IDLE: begin
          if (event_i.mode == EV_START) begin
            next_ph = PH_NEG;
          end else if ((event_i.mode == EV_OFFER) ||
                       ((event_i.mode == EV_MANIFEST) && event_i.manifest_accept)) begin
            next_ph = PH_NEG;
            act_cnt = 2'd1;
            act0    = ACT_STORE;
          end
        end
        PH_NEG: begin
          if ((event_i.mode == EV_OFFER) ||
              ((event_i.mode == EV_MANIFEST) && event_i.manifest_accept)) begin
            act_cnt = 2'd1;
            act0    = ACT_STORE;
          end else if (event_i.mode == EV_ACCEPTED) begin
            next_ph = PH_RECV;
            act_cnt = 2'd2;
            act0    = ACT_RESET;
            act1    = ACT_BEGIN;
          end
        end
        PH_RECV: begin
          if (event_i.mode == EV_CHUNK) begin
            act_cnt = 2'd1;
            act0    = ACT_APPLY;
          end else if (event_i.mode == EV_REJECT) begin
            act_cnt = 2'd1;
            act0    = ACT_PENAL;
          end else if (event_i.mode == EV_COMPLETE) begin
            next_ph = PH_VERIFY;
            act_cnt = 2'd1;
            act0    = ACT_VERIFY;
          end
        end
        PH_VERIFY: begin
          if (event_i.mode == EV_PROOF) begin
            act_cnt = 2'd1;
            if (event_i.proof_passed) begin
              next_ph = PH_STAGED;
              act0    = ACT_STAGE;
            end else begin
              next_ph   = PH_FAILED;
              act0      = ACT_FAIL;
              blk       = BLK_PROOF;
              blk_valid = 1'b1;
            end
          end
        end
        PH_STAGED, PH_CONTAIN: begin
          if ((event_i.mode == EV_START) || (event_i.mode == EV_OFFER) ||
              (event_i.mode == EV_ACCEPTED) || (event_i.mode == EV_CHUNK) ||
              (event_i.mode == EV_COMPLETE) || (event_i.mode == EV_PROOF)) begin
            next_ph   = PH_CONTAIN;
            act_cnt   = 2'd1;
            act0      = ACT_CONTAIN;
            blk       = BLK_CONTAINED;
            blk_valid = 1'b1;
          end
        end
        default: begin
          next_ph = state_i.phase;
        end
      endcase
    end
  end

  // State after the event: adoption, action effects, then the clear on idle.
  always_comb begin
    nx = state_i;
    if (!stale) begin
      nx.phase = next_ph;
      if ((state_i.session == 64'd0) && (state_i.phase == PH_IDLE) &&
          (next_ph != PH_IDLE)) begin
        nx.session = event_i.session_tag;
        nx.peer    = event_i.peer_tag;
      end
      if ((act_cnt != 2'd0) && (act0 == ACT_STORE)) begin
        nx.height   = event_i.offer_height;
        nx.total    = COUNT_BITS'({32'd0, event_i.offer_chunk_total});
        nx.received = '0;
        nx.root     = ev_root;
        nx.proven   = 1'b0;
      end
      if ((act_cnt != 2'd0) && (act0 == ACT_RESET)) begin
        nx.received = '0;
      end
      if ((act_cnt != 2'd0) && (act0 == ACT_APPLY) && (state_i.received < state_i.total)) begin
        nx.received = state_i.received + COUNT_BITS'(1);
      end
      if ((act_cnt != 2'd0) && (act0 == ACT_STAGE)) begin
        nx.proven = 1'b1;
      end
      if ((next_ph == PH_IDLE) && (state_i.phase != PH_IDLE)) begin
        nx = '0;
      end
    end
  end

  assign state_o   = nx;
  assign total_ext = 64'(nx.total);
  assign recv_ext  = 64'(nx.received);

  // Result record: the state after the step and the action codes.
  always_comb begin
    record_o.phase         = nx.phase;
    record_o.act0          = (stale || (act_cnt == 2'd0)) ? ACT_NONE : act0;
    record_o.act1          = act1;
    record_o.two           = !stale && (act_cnt == 2'd2);
    record_o.blocker       = stale ? BLK_NONE : blk;
    record_o.blocker_valid = !stale && blk_valid;
    record_o.session       = nx.session;
    record_o.peer          = nx.peer;
    record_o.height        = nx.height;
    record_o.total         = total_ext[31:0];
    record_o.received      = recv_ext[31:0];
    record_o.proven        = nx.proven;
  end

endmodule

// ===== rtl/sssf_out_stage.sv =====
// ----------------------------------------------------------------------------
// sssf_out_stage: result register and serialiser
// Holds the record of one event and presents its one or two results on the
// output stream, one transfer per result.
// ----------------------------------------------------------------------------
module sssf_out_stage (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  sssf_pkg::record_t                   record_i,
  output logic                                free_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata, lowest bit up: phase_out, blocker_code, blocker_valid, session_out,
  // peer_out, height_out, total_out, received_out, proven_out
  output logic [sssf_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // tuser: action_code
  output logic [sssf_pkg::OUT_USER_W-1:0]     m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);
  import sssf_pkg::*;

  record_t rec_q;
  logic    valid_q;
  logic    idx_q;
  logic    last;
  logic    xfer;

  assign last   = !rec_q.two || idx_q;
  assign xfer   = valid_q && m_axis_tready_i;
  assign free_o = !valid_q || (xfer && last);

  // Record payload, loaded when a held event moves into the free slot.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= record_i;
    end
  end

  // Slot occupancy and result index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 1'b0;
    end else if (xfer && last) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (xfer) begin
      idx_q   <= 1'b1;
    end
  end

  // Output stream fields.
  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tlast_o  = last;
  assign m_axis_tuser_o  = idx_q ? rec_q.act1 : rec_q.act0;
  assign m_axis_tdata_o  = {rec_q.proven, rec_q.received, rec_q.total, rec_q.height,
                            rec_q.peer, rec_q.session, rec_q.blocker_valid,
                            rec_q.blocker, rec_q.phase};

endmodule

// ===== rtl/snapshot_sync_session_fsm.sv =====
// ----------------------------------------------------------------------------
// snapshot_sync_session_fsm: snapshot-download session controller
// Path: an event passes the input register and then the result register, which
//   offers its first result.
// Throughput: one event per cycle when it gives one result and the output is
//   ready; an event with two results holds the single result register until
//   its second result is taken.
// Reset: asynchronous and active low; the phase returns to idle and all session
//   state, the stored root and both stream stages are cleared.
// ----------------------------------------------------------------------------
module snapshot_sync_session_fsm (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata, lowest bit up: session_tag, peer_tag, offer_height,
  // offer_chunk_total, manifest_accept, proof_passed, root_word0..root_word3
  input  logic [sssf_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // tuser: mode
  input  logic [sssf_pkg::IN_USER_W-1:0]      s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata, lowest bit up: phase_out, blocker_code, blocker_valid, session_out,
  // peer_out, height_out, total_out, received_out, proven_out
  output logic [sssf_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o,
  // tuser: action_code
  output logic [sssf_pkg::OUT_USER_W-1:0]     m_axis_tuser_o,
  output logic                                m_axis_tlast_o
);
  import sssf_pkg::*;

  event_t  ev_q;
  event_t  ev_d;
  logic    in_valid_q;
  logic    advance;
  logic    free;
  state_t  state_q;
  state_t  state_d;
  record_t record;

  // Unpack the input transfer.
  always_comb begin
    ev_d.mode              = s_axis_tuser_i;
    ev_d.session_tag       = s_axis_tdata_i[63:0];
    ev_d.peer_tag          = s_axis_tdata_i[127:64];
    ev_d.offer_height      = s_axis_tdata_i[159:128];
    ev_d.offer_chunk_total = s_axis_tdata_i[191:160];
    ev_d.manifest_accept   = s_axis_tdata_i[192];
    ev_d.proof_passed      = s_axis_tdata_i[193];
    for (int i = 0; i < ROOT_IN_WORDS; i++) begin
      ev_d.root[i] = s_axis_tdata_i[194 + 64*i +: 64];
    end
  end

  // The held event moves on once the result register can take its record.
  assign advance         = in_valid_q && free;
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      ev_q <= ev_d;
    end
  end

  // Input register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  sssf_decide u_decide (
    .state_i  (state_q),
    .event_i  (ev_q),
    .state_o  (state_d),
    .record_o (record)
  );

  // Session state, updated as each event is decided.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  sssf_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (advance),
    .record_i        (record),
    .free_o          (free),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // The second result of an event always follows its first.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |=> m_axis_tvalid_o)
    else $error("second result of an event was dropped");

  // Events that raise a blocker give a single result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[6]) |-> m_axis_tlast_o)
    else $error("blocker raised on a two-result event");

  // The received count never passes the chunk total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.received <= state_q.total)
    else $error("received count above chunk total");

  // An idle controller holds no session.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase == PH_IDLE) |-> (state_q.session == 64'd0))
    else $error("session kept while idle");

endmodule
